// File: rtl/matrix_multiply_assert.svh
// Assertion macros for the matrix multiply block.
// MM_ASSERT is sampled on clk and is off while rst_n is low.
// MM_ASSERT_NORST is sampled on clk at every edge, reset included.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH
`ifndef SYNTHESIS
`define MM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MM_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MM_ASSERT(lbl, prop, msg)
`define MM_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// File: rtl/mm_pkg.sv
package mm_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 6;
    localparam int DEPTH     = 64;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    // 32 x 32 full products of 64 bits plus sign and rounding fit easily
    localparam int ACC_W     = 72;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_COMPUTE    = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic              issue;      // one multiply-accumulate term this cycle
        logic              first;      // first term of a dot product
        logic              last_term;  // last term of a dot product
        logic              last_run;   // dot product is the final one of the run
        logic [ADDR_W-1:0] left_addr;
        logic [ADDR_W-1:0] right_addr;
        logic [ADDR_W-1:0] idx;
    } mm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_out;
    } mm_status_t;

endpackage

// File: rtl/mm_ctrl.sv
module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    command,
    input  logic                          cfg_write,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
    input  mm_pkg::mm_status_t            status,
    output mm_pkg::mm_cmd_t               cmd,
    output logic                          busy
);
    import mm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int MW    = 2 * DIM_W + 1;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0]  i_reg, j_reg, k_reg;
    logic [ADDR_W-1:0] n_reg;

    logic accept;
    logic last_term;
    logic last_col;
    logic last_run;
    logic [MW-1:0] left_lin, right_lin;

    // zero acts as one, anything above MAX_DIM is clamped
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] r;
        if (raw == '0)
            r = DIM_W'(1);
        else if (32'(raw) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(raw);
        return r;
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign last_term = (k_reg == inner_reg - DIM_W'(1));
    assign last_col  = (j_reg == cols_reg - DIM_W'(1));
    // at most 64 results per run
    assign last_run  = (last_col && (i_reg == rows_reg - DIM_W'(1))) || (n_reg == '1);

    assign left_lin  = MW'(i_reg) * MW'(inner_reg) + MW'(k_reg);
    assign right_lin = MW'(k_reg) * MW'(cols_reg) + MW'(j_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_COMPUTE))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (last_term && last_run)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (status.last_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.left_addr  = ADDR_W'(left_lin);
        cmd.right_addr = ADDR_W'(right_lin);
        cmd.idx        = n_reg;
        cmd.first      = (k_reg == '0);
        cmd.last_term  = last_term;
        cmd.last_run   = last_run;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_left  = accept && (command == CMD_LOAD_LEFT);
                cmd.wr_right = accept && (command == CMD_LOAD_RIGHT);
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            default:
            begin
                cmd.issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
            begin
                if (last_term)
                begin
                    k_reg <= '0;
                    n_reg <= n_reg + ADDR_W'(1);
                    if (last_col)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + DIM_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + DIM_W'(1);
                end
            end
            else if (state_reg == ST_IDLE)
            begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
                n_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(1);
            inner_reg <= DIM_W'(1);
            cols_reg  <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_COUNT:   rows_reg  <= eff_dim(cfg_data);
                REG_INNER_COUNT: inner_reg <= eff_dim(cfg_data);
                REG_COL_COUNT:   cols_reg  <= eff_dim(cfg_data);
                default:         ;
            endcase
        end
    end

endmodule

// File: rtl/mm_datapath.sv
module mm_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mm_pkg::mm_cmd_t                   cmd,
    input  logic [mm_pkg::ADDR_W-1:0]         elem_index,
    input  logic signed [mm_pkg::DATA_W-1:0]  elem_value,
    output mm_pkg::mm_status_t                status,
    output logic                              result_valid,
    output logic signed [mm_pkg::DATA_W-1:0]  prod_value,
    output logic [mm_pkg::ADDR_W-1:0]         prod_index,
    output logic                              is_last
);
    import mm_pkg::*;

    // round half up: add half an LSB before the floor shift
    localparam logic [ACC_W-1:0] RND = (ACC_W'(1) << FRAC_BITS) >> 1;

    logic signed [DATA_W-1:0] left_mem  [DEPTH];
    logic signed [DATA_W-1:0] right_mem [DEPTH];

    logic signed [DATA_W-1:0] left_rd_reg, right_rd_reg;
    logic                     s1_vld_reg, s1_first_reg, s1_term_reg, s1_run_reg;
    logic [ADDR_W-1:0]        s1_idx_reg;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       s2_vld_reg, s2_first_reg, s2_term_reg, s2_run_reg;
    logic [ADDR_W-1:0]          s2_idx_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    fin_vld_reg, fin_run_reg;
    logic [ADDR_W-1:0]       fin_idx_reg;

    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-DATA_W:0]    upper;
    logic signed [DATA_W-1:0] sat_value;

    logic                     result_valid_reg;
    logic signed [DATA_W-1:0] prod_value_reg;
    logic [ADDR_W-1:0]        prod_index_reg;
    logic                     is_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_left)
            left_mem[elem_index] <= elem_value;
        left_rd_reg <= left_mem[cmd.left_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_right)
            right_mem[elem_index] <= elem_value;
        right_rd_reg <= right_mem[cmd.right_addr];
    end

    assign acc_next  = (s2_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);

    assign rounded   = acc_reg + $signed(RND);
    assign shifted   = rounded >>> FRAC_BITS;
    assign upper     = shifted[ACC_W-1:DATA_W-1];
    assign sat_value = ((&upper) || !(|upper)) ? shifted[DATA_W-1:0]
                     : (shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}});

    // payload stages
    always_ff @(posedge clk)
    begin
        s1_first_reg   <= cmd.first;
        s1_term_reg    <= cmd.last_term;
        s1_run_reg     <= cmd.last_run;
        s1_idx_reg     <= cmd.idx;
        prod_reg       <= left_rd_reg * right_rd_reg;
        s2_first_reg   <= s1_first_reg;
        s2_term_reg    <= s1_term_reg;
        s2_run_reg     <= s1_run_reg;
        s2_idx_reg     <= s1_idx_reg;
        fin_run_reg    <= s2_run_reg;
        fin_idx_reg    <= s2_idx_reg;
        prod_value_reg <= sat_value;
        prod_index_reg <= fin_idx_reg;
        if (s2_vld_reg)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            fin_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            is_last_reg      <= 1'b0;
        end
        else
        begin
            s1_vld_reg       <= cmd.issue;
            s2_vld_reg       <= s1_vld_reg;
            fin_vld_reg      <= s2_vld_reg && s2_term_reg;
            result_valid_reg <= fin_vld_reg;
            is_last_reg      <= fin_vld_reg && fin_run_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign prod_value      = prod_value_reg;
    assign prod_index      = prod_index_reg;
    assign is_last         = is_last_reg;
    assign status.last_out = result_valid_reg && is_last_reg;

endmodule

// File: rtl/matrix_multiply.sv
// Fixed-point (signed Q16.16 by default) dense matrix product.
// Input: an item is taken on a clock edge with start high and busy low.
//   command load-left / load-right writes elem_value at elem_index of the
//   left or right store in that one cycle; busy stays low.
//   command compute raises busy and walks the product row by row.
// Dimensions are set through cfg_write / cfg_index / cfg_data (row, inner,
//   column count); the user must write them only while busy is low, which
//   the block does not enforce. Zero acts as one, above MAX_DIM as MAX_DIM.
// Output: each product element appears for one cycle with result_valid high,
//   plus prod_index and is_last on the final element. Nothing can stall it.
// Timing: one shared multiply-accumulate unit takes one term per cycle from
//   single-port reads of the two stores, for N = rows*cols*inner terms
//   (capped at 64 dot products). Each result passes the read registers, the
//   product register, the accumulator and the saturated output register.
// Reset: rst_n clears control and sets all dimensions to one; store contents
//   are unknown until loaded.
`include "matrix_multiply_assert.svh"

module matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [mm_pkg::ADDR_W-1:0]         elem_index,
    input  logic signed [mm_pkg::DATA_W-1:0]  elem_value,
    input  logic                              cfg_write,
    input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]          cfg_data,
    output logic                              result_valid,
    output logic signed [mm_pkg::DATA_W-1:0]  prod_value,
    output logic [mm_pkg::ADDR_W-1:0]         prod_index,
    output logic                              is_last
);
    import mm_pkg::*;

    mm_cmd_t    cmd;
    mm_status_t status;

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    mm_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .elem_index   (elem_index),
        .elem_value   (elem_value),
        .status       (status),
        .result_valid (result_valid),
        .prod_value   (prod_value),
        .prod_index   (prod_index),
        .is_last      (is_last)
    );

    `MM_ASSERT_NORST(a_quiet_in_reset, !rst_n |=> (!busy && !result_valid), "activity during reset")
    `MM_ASSERT(a_result_while_busy, result_valid |-> busy, "result transfer while idle")
    `MM_ASSERT(a_idle_after_last, (result_valid && is_last) |=> !busy, "busy after final result")
    `MM_ASSERT(a_busy_from_compute, $rose(busy) |-> ($past(start) && ($past(command) == CMD_COMPUTE)), "busy without compute")

endmodule

// File: verif/tb_top.sv
module tb_top;
    import mm_pkg::*;

    localparam int MAX_DIM      = 8;
    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 30;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ADDR_W-1:0] index;
        logic              last;
    } product_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               command = CMD_LOAD_LEFT;
    logic [ADDR_W-1:0]        elem_index = '0;
    logic signed [DATA_W-1:0] elem_value = '0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_ROW_COUNT;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     result_valid;
    logic signed [DATA_W-1:0] prod_value;
    logic [ADDR_W-1:0]        prod_index;
    logic                     is_last;

    // shadow of the block: dimension registers and both element stores
    logic [CFG_W-1:0]  row_cfg = 4'd1;
    logic [CFG_W-1:0]  inner_cfg = 4'd1;
    logic [CFG_W-1:0]  col_cfg = 4'd1;
    logic [DATA_W-1:0] left_copy [DEPTH];
    logic [DATA_W-1:0] right_copy [DEPTH];
    bit                left_written [DEPTH];
    bit                right_written [DEPTH];

    product_t expected_products [$];
    product_t checked_product;
    int       mismatch_count = 0;
    int       items_accepted = 0;
    int       cycle_count = 0;
    bit       burst_mode = 1'b0;

    matrix_multiply #(
        .MAX_DIM(MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .elem_index(elem_index),
        .elem_value(elem_value),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .prod_value(prod_value),
        .prod_index(prod_index),
        .is_last(is_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL matrix_multiply");
            $finish;
        end
    end

    function automatic int effective_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    // expected product matrix for the current dimensions and store contents
    function automatic void predict_product();
        int rows;
        int inner;
        int cols;
        int total;
        int n;
        logic signed [127:0] acc;
        logic signed [63:0]  term;
        product_t p;
        rows = effective_dim(row_cfg);
        inner = effective_dim(inner_cfg);
        cols = effective_dim(col_cfg);
        total = (rows * cols < DEPTH) ? rows * cols : DEPTH;
        n = 0;
        for (int i = 0; i < rows; i++)
        begin
            for (int j = 0; j < cols; j++)
            begin
                if (n < total)
                begin
                    acc = '0;
                    for (int k = 0; k < inner; k++)
                    begin
                        term = $signed(left_copy[ADDR_W'(i * inner + k)]) *
                               $signed(right_copy[ADDR_W'(k * cols + j)]);
                        acc = acc + term;
                    end
                    // round half up, then floor shift
                    if (FRAC_BITS > 0)
                        acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
                    acc = acc >>> FRAC_BITS;
                    if (acc > SAT_HI)
                        p.value = 32'h7FFF_FFFF;
                    else if (acc < SAT_LO)
                        p.value = 32'h8000_0000;
                    else
                        p.value = acc[DATA_W-1:0];
                    p.index = ADDR_W'(i * cols + j);
                    p.last = (n == total - 1);
                    expected_products.push_back(p);
                    n++;
                end
            end
        end
    endfunction

    function automatic void apply_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] idx,
                                       input logic [DATA_W-1:0] val);
        case (cmd)
            CMD_LOAD_LEFT:
            begin
                left_copy[idx] = val;
                left_written[idx] = 1'b1;
            end
            CMD_LOAD_RIGHT:
            begin
                right_copy[idx] = val;
                right_written[idx] = 1'b1;
            end
            CMD_COMPUTE: predict_product();
            default: ;
        endcase
    endfunction

    // start stays high after a transfer; the next call either keeps it or drops it
    task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        elem_index <= idx;
        elem_value <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_item(cmd, idx, val);
        if (cmd != CMD_UNUSED)
            items_accepted++;
    endtask

    // wait for the block to go idle with every product received
    task automatic settle();
        start <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] i,
                            input logic [CFG_W-1:0] c);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data <= r;
        @(posedge clk);
        cfg_index <= REG_INNER_COUNT;
        cfg_data <= i;
        @(posedge clk);
        cfg_index <= REG_COL_COUNT;
        cfg_data <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
        row_cfg = r;
        inner_cfg = i;
        col_cfg = c;
    endtask

    // load any element the product will read that was never written, then compute
    task automatic run_compute();
        int rows;
        int inner;
        int cols;
        rows = effective_dim(row_cfg);
        inner = effective_dim(inner_cfg);
        cols = effective_dim(col_cfg);
        for (int a = 0; a < rows * inner; a++)
            if (!left_written[ADDR_W'(a)])
                send_item(CMD_LOAD_LEFT, ADDR_W'(a), random_value());
        for (int a = 0; a < inner * cols; a++)
            if (!right_written[ADDR_W'(a)])
                send_item(CMD_LOAD_RIGHT, ADDR_W'(a), random_value());
        send_item(CMD_COMPUTE, ADDR_W'($urandom()), $urandom());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected product: value %h index %0d last %b",
                             prod_value, prod_index, is_last);
            end
            else
            begin
                checked_product = expected_products.pop_front();
                if (prod_value !== checked_product.value ||
                    prod_index !== checked_product.index ||
                    is_last !== checked_product.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("product mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                                 checked_product.value, checked_product.index,
                                 checked_product.last, prod_value, prod_index, is_last);
                end
            end
        end
    end

    // dimensions straight out of reset are 1x1x1
    task automatic test_reset_dims();
        send_item(CMD_LOAD_LEFT, 6'd0, 32'h0002_0000);
        send_item(CMD_LOAD_RIGHT, 6'd0, 32'h0001_8000);
        run_compute();
    endtask

    // half an LSB rounds up, for both signs
    task automatic test_rounding();
        send_item(CMD_LOAD_LEFT, 6'd0, 32'h0000_0001);
        send_item(CMD_LOAD_RIGHT, 6'd0, 32'h0000_8000);
        run_compute();
        send_item(CMD_LOAD_LEFT, 6'd0, 32'hFFFF_FFFF);
        run_compute();
    endtask

    // unused command and loads outside the matrix leave the product alone
    task automatic test_stray_items();
        send_item(CMD_LOAD_LEFT, 6'd63, random_value());
        send_item(CMD_LOAD_RIGHT, 6'd40, random_value());
        send_item(CMD_UNUSED, ADDR_W'($urandom()), $urandom());
        run_compute();
    endtask

    task automatic test_saturation();
        set_dims(4'd1, 4'd2, 4'd1);
        send_item(CMD_LOAD_LEFT, 6'd0, 32'h7FFF_FFFF);
        send_item(CMD_LOAD_LEFT, 6'd1, 32'h7FFF_FFFF);
        send_item(CMD_LOAD_RIGHT, 6'd0, 32'h7FFF_FFFF);
        send_item(CMD_LOAD_RIGHT, 6'd1, 32'h7FFF_FFFF);
        run_compute();
        send_item(CMD_LOAD_RIGHT, 6'd0, 32'h8000_0000);
        send_item(CMD_LOAD_RIGHT, 6'd1, 32'h8000_0000);
        run_compute();
        send_item(CMD_LOAD_LEFT, 6'd0, 32'h8000_0000);
        send_item(CMD_LOAD_LEFT, 6'd1, 32'h8000_0000);
        run_compute();
    endtask

    // zero acts as one, above the maximum acts as the maximum
    task automatic test_dim_extremes();
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data <= 4'hF;
        @(posedge clk);
        cfg_write <= 1'b0;
        set_dims(4'd0, 4'd0, 4'd0);
        run_compute();
        set_dims(4'd1, 4'd8, 4'd1);
        run_compute();
        set_dims(4'd8, 4'd1, 4'd8);
        run_compute();
        set_dims(4'd15, 4'd15, 4'd15);
        run_compute();
    endtask

    task automatic test_random();
        int first_count;
        int rows;
        int inner;
        int cols;
        int noise;
        logic [CFG_W-1:0] dim [3];
        first_count = items_accepted;
        while (items_accepted - first_count < RANDOM_ITEMS)
        begin
            for (int d = 0; d < 3; d++)
                dim[d] = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 3));
            set_dims(dim[0], dim[1], dim[2]);
            burst_mode = ($urandom_range(0, 3) == 0);
            rows = effective_dim(dim[0]);
            inner = effective_dim(dim[1]);
            cols = effective_dim(dim[2]);
            if ($urandom_range(0, 3) != 0)
            begin
                // full reload of both operands
                for (int a = 0; a < rows * inner; a++)
                    send_item(CMD_LOAD_LEFT, ADDR_W'(a), random_value());
                for (int a = 0; a < inner * cols; a++)
                    send_item(CMD_LOAD_RIGHT, ADDR_W'(a), random_value());
            end
            else
            begin
                noise = $urandom_range(1, 6);
                for (int a = 0; a < noise; a++)
                    send_item($urandom_range(0, 1) ? CMD_LOAD_RIGHT :
                              ($urandom_range(0, 3) == 0 ? CMD_UNUSED : CMD_LOAD_LEFT),
                              ADDR_W'($urandom()), random_value());
            end
            run_compute();
            // second compute, requested while the first is still running and taken once busy falls
            if ($urandom_range(0, 2) == 0)
                run_compute();
            burst_mode = 1'b0;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_dims();
        test_rounding();
        test_stray_items();
        test_saturation();
        test_dim_extremes();
        test_random();
        settle();
        if (mismatch_count == 0)
            $display("PASS matrix_multiply");
        else
            $display("FAIL matrix_multiply");
        $finish;
    end

endmodule
